[design/esd_pkg.sv]
// Package for the string escape decoder: shared types, character codes,
// status codes and the small decode functions used by the front end.
// Depends on nothing; every other file of the block but esd_if.sv refers to it.
`default_nettype none

package esd_pkg;

   // Quote handling limits.
   localparam int QUOTE_MAX = 3;
   localparam int HELD_DEPTH = QUOTE_MAX - 1;
   localparam int MAX_RESULTS = 3;
   localparam logic [1:0] QLEN_MAX = 2'(QUOTE_MAX);

   // Result status codes.
   localparam logic [1:0] ST_DATA = 2'd0;
   localparam logic [1:0] ST_END = 2'd1;
   localparam logic [1:0] ST_BAD_HEX = 2'd2;
   localparam logic [1:0] ST_BAD_ESC = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_QUOTE_LEN = 1'b0;
   localparam logic CSR_QUOTE_CHARS = 1'b1;

   // Characters of interest.
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_X = 8'h78;
   localparam logic [7:0] CH_U = 8'h75;

   // Control characters produced by escapes.
   localparam logic [7:0] CC_BACKSPACE = 8'h08;
   localparam logic [7:0] CC_FORMFEED = 8'h0C;
   localparam logic [7:0] CC_NEWLINE = 8'h0A;
   localparam logic [7:0] CC_RETURN = 8'h0D;
   localparam logic [7:0] CC_TAB = 8'h09;

   // Parser mode, one-hot.
   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_ESC    = 4'b0010,
      MODE_HEX_X  = 4'b0100,
      MODE_HEX_U  = 4'b1000
   } mode_type;

   // Configuration register contents.
   typedef struct packed {
      logic [1:0]  quote_len;
      logic [23:0] quote_chars;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] status;
   } slot_type;

   // All results caused by one request, oldest in slot 0.
   typedef struct packed {
      logic [1:0]                     count;
      slot_type [MAX_RESULTS-1:0]     slot;
   } bundle_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       known;
      logic [7:0] value;
   } esc_type;

   // Value of one hex digit character.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r.ok = 1'b1;
         r.value = 4'(c - CH_ZERO);
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         r.ok = 1'b1;
         r.value = 4'(c - CH_UPPER_A + 8'd10);
      end else if (c >= CH_LOWER_A && c <= CH_F) begin
         r.ok = 1'b1;
         r.value = 4'(c - CH_LOWER_A + 8'd10);
      end
      return r;
   endfunction

   // Single-byte escapes; the hex escapes are handled by the caller.
   function automatic esc_type esc_decode(input logic [7:0] c);
      esc_type r;
      r.known = 1'b1;
      r.value = c;
      case (c)
         CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH: r.value = c;
         CH_B: r.value = CC_BACKSPACE;
         CH_F: r.value = CC_FORMFEED;
         CH_N: r.value = CC_NEWLINE;
         CH_R: r.value = CC_RETURN;
         CH_T: r.value = CC_TAB;
         CH_ZERO: r.value = CH_NUL;
         default: r.known = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[design/esd_if.sv]
// Valid/ready channel interfaces of the string escape decoder: request,
// response and configuration write. No dependencies.
`default_nettype none

interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       first;

   modport source (output valid, output in_byte, output first, input ready);
   modport sink (input valid, input in_byte, input first, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output status, output last,
                   input ready);
   modport sink (input valid, input out_byte, input status, input last,
                 output ready);
endinterface

interface esd_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/string_escape_decoder_unit.sv]
// String escape decoder. Accepts one source byte per cycle while the result
// queue has room and produces the decoded bytes, an end result at the
// closing quote or a NUL, or an error result carrying the offending byte.
// The front end decodes each byte in the cycle it is accepted and writes
// the zero to three results it causes into a queue of QUEUE_DEPTH entries;
// the back end delivers one result per cycle while the receiver is ready.
// Sustained rate is one byte per cycle while bytes give at most one result
// each and the output is not stalled; \u escapes of two or three UTF-8
// bytes are set by the single output port. The first result of a byte
// passes through the queue entry and then the output stage register
// before it is offered.
// Depends on esd_pkg, the channel interfaces and the esd_* submodules.
`default_nettype none

module string_escape_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire          clock,
   input  wire          reset,
   esd_req_if.sink      req_bus,
   esd_rsp_if.source    rsp_bus,
   esd_csr_if.sink      csr_bus
);

   esd_pkg::cfg_type    cfg;
   esd_pkg::bundle_type push_data;
   esd_pkg::bundle_type pop_data;
   logic                push_valid;
   logic                queue_full;
   logic                pop;
   logic                pop_valid;

   // Configuration registers.
   esd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   // Byte decode.
   esd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Result bundle queue.
   esd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // Result delivery.
   esd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (pop_valid),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire

[design/esd_csr.sv]
// Configuration registers of the string escape decoder (quote length and
// quote bytes). Depends on esd_pkg and esd_csr_if.
`default_nettype none

module esd_csr (
   input  wire                clock,
   input  wire                reset,
   esd_csr_if.sink            csr,
   output esd_pkg::cfg_type   cfg
);

   logic [1:0]  quote_len_ff;
   logic [1:0]  quote_len_in;
   logic [23:0] quote_chars_ff;
   logic [23:0] quote_chars_in;

   // Writes are always taken.
   assign csr.ready = 1'b1;

   // Register decode.
   always_comb begin
      quote_len_in = quote_len_ff;
      quote_chars_in = quote_chars_ff;
      if (csr.valid) begin
         case (csr.index)
            esd_pkg::CSR_QUOTE_LEN: quote_len_in = csr.data[1:0];
            esd_pkg::CSR_QUOTE_CHARS: quote_chars_in = csr.data;
            default: quote_len_in = quote_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_len_ff <= 2'd1;
         quote_chars_ff <= 24'd34;
      end else begin
         quote_len_ff <= quote_len_in;
         quote_chars_ff <= quote_chars_in;
      end
   end

   assign cfg.quote_len = quote_len_ff;
   assign cfg.quote_chars = quote_chars_ff;

endmodule

`default_nettype wire

[design/esd_front.sv]
// Front end of the string escape decoder: accepts one source byte per
// cycle while the result queue has room, keeps the parser state and builds
// the bundle of results that the byte causes. Depends on esd_pkg and esd_req_if.
`default_nettype none

module esd_front (
   input  wire                   clock,
   input  wire                   reset,
   esd_req_if.sink               req,
   input  esd_pkg::cfg_type      cfg,
   input  wire                   queue_full,
   output logic                  push_valid,
   output esd_pkg::bundle_type   push_data
);

   esd_pkg::mode_type mode_ff, mode_in, mode_cur;
   logic [15:0] hex_value_ff, hex_value_in, hex_value_cur, hex_next;
   logic [2:0]  hex_left_ff, hex_left_in, hex_left_cur, hex_left_next;
   logic [7:0]  held_ff [esd_pkg::HELD_DEPTH];
   logic [7:0]  held_in [esd_pkg::HELD_DEPTH];
   logic [1:0]  held_cnt_ff, held_cnt_in, held_cnt_cur;
   logic        finished_ff, finished_in, finished_cur;
   logic        accept;

   // Working values of the decode.
   logic [7:0]  c;
   logic [1:0]  cnt;
   logic [1:0]  qlen;
   logic [1:0]  sel;
   logic [2:0]  span;
   logic        found;
   logic [7:0]  win_q [esd_pkg::QUOTE_MAX];
   logic [esd_pkg::QUOTE_MAX-1:0] match;
   esd_pkg::hex_type hex_d;
   esd_pkg::esc_type esc_d;
   esd_pkg::bundle_type bundle;

   assign req.ready = !queue_full;
   assign accept = req.valid && req.ready;
   assign c = req.in_byte;

   // Decode of one byte against the current parser state.
   always_comb begin
      // A first byte starts from cleared state.
      if (req.first) begin
         mode_cur = esd_pkg::MODE_NORMAL;
         hex_value_cur = '0;
         hex_left_cur = '0;
         held_cnt_cur = '0;
         finished_cur = 1'b0;
      end else begin
         mode_cur = mode_ff;
         hex_value_cur = hex_value_ff;
         hex_left_cur = hex_left_ff;
         held_cnt_cur = held_cnt_ff;
         finished_cur = finished_ff;
      end

      mode_in = mode_cur;
      hex_value_in = hex_value_cur;
      hex_left_in = hex_left_cur;
      held_cnt_in = held_cnt_cur;
      finished_in = finished_cur;
      for (int j = 0; j < esd_pkg::HELD_DEPTH; j++) begin
         held_in[j] = held_ff[j];
      end
      bundle = '0;

      // Quote window: held bytes followed by the new byte.
      cnt = (held_cnt_cur > 2'(esd_pkg::HELD_DEPTH)) ? 2'(esd_pkg::HELD_DEPTH)
                                                      : held_cnt_cur;
      qlen = (cfg.quote_len > esd_pkg::QLEN_MAX) ? esd_pkg::QLEN_MAX : cfg.quote_len;
      for (int k = 0; k < esd_pkg::QUOTE_MAX; k++) begin
         if (k < esd_pkg::HELD_DEPTH) begin
            win_q[k] = held_ff[k];
         end else begin
            win_q[k] = c;
         end
      end
      win_q[cnt] = c;

      // Prefix match of the window from each starting offset.
      for (int s = 0; s < esd_pkg::QUOTE_MAX; s++) begin
         match[s] = 1'b1;
         for (int i = 0; i < esd_pkg::QUOTE_MAX; i++) begin
            if (s + i < esd_pkg::QUOTE_MAX) begin
               if (i < int'(qlen) && (s + i) <= int'(cnt)
                   && win_q[s + i] != cfg.quote_chars[8*i +: 8]) begin
                  match[s] = 1'b0;
               end
            end
         end
      end

      // Oldest offset that still matches, or the new byte alone.
      found = 1'b0;
      sel = cnt;
      for (int s = 0; s < esd_pkg::QUOTE_MAX; s++) begin
         if (!found && s <= int'(cnt) && (match[s] || s == int'(cnt))) begin
            found = 1'b1;
            sel = 2'(s);
         end
      end
      span = 3'(cnt) - 3'(sel) + 3'd1;

      hex_d = esd_pkg::hex_decode(c);
      esc_d = esd_pkg::esc_decode(c);
      hex_next = {hex_value_cur[11:0], hex_d.value};
      hex_left_next = (hex_left_cur != 3'd0) ? hex_left_cur - 3'd1 : 3'd0;

      if (!finished_cur) begin
         case (mode_cur)
            esd_pkg::MODE_ESC: begin
               mode_in = esd_pkg::MODE_NORMAL;
               if (c == esd_pkg::CH_X) begin
                  mode_in = esd_pkg::MODE_HEX_X;
                  hex_value_in = '0;
                  hex_left_in = 3'd2;
               end else if (c == esd_pkg::CH_U) begin
                  mode_in = esd_pkg::MODE_HEX_U;
                  hex_value_in = '0;
                  hex_left_in = 3'd4;
               end else if (esc_d.known) begin
                  bundle.count = 2'd1;
                  bundle.slot[0] = '{data: esc_d.value, status: esd_pkg::ST_DATA};
               end else begin
                  bundle.count = 2'd1;
                  bundle.slot[0] = '{data: c, status: esd_pkg::ST_BAD_ESC};
                  finished_in = 1'b1;
                  held_cnt_in = '0;
               end
            end

            esd_pkg::MODE_HEX_X, esd_pkg::MODE_HEX_U: begin
               if (!hex_d.ok) begin
                  bundle.count = 2'd1;
                  bundle.slot[0] = '{data: c, status: esd_pkg::ST_BAD_HEX};
                  finished_in = 1'b1;
                  held_cnt_in = '0;
                  mode_in = esd_pkg::MODE_NORMAL;
               end else begin
                  hex_value_in = hex_next;
                  hex_left_in = hex_left_next;
                  if (hex_left_next == 3'd0) begin
                     mode_in = esd_pkg::MODE_NORMAL;
                     hex_value_in = '0;
                     // Byte value, or the UTF-8 form of the code point.
                     if (mode_cur == esd_pkg::MODE_HEX_X || hex_next < 16'h0080) begin
                        bundle.count = 2'd1;
                        bundle.slot[0] = '{data: hex_next[7:0],
                                           status: esd_pkg::ST_DATA};
                     end else if (hex_next < 16'h0800) begin
                        bundle.count = 2'd2;
                        bundle.slot[0] = '{data: {3'b110, hex_next[10:6]},
                                           status: esd_pkg::ST_DATA};
                        bundle.slot[1] = '{data: {2'b10, hex_next[5:0]},
                                           status: esd_pkg::ST_DATA};
                     end else begin
                        bundle.count = 2'd3;
                        bundle.slot[0] = '{data: {4'b1110, hex_next[15:12]},
                                           status: esd_pkg::ST_DATA};
                        bundle.slot[1] = '{data: {2'b10, hex_next[11:6]},
                                           status: esd_pkg::ST_DATA};
                        bundle.slot[2] = '{data: {2'b10, hex_next[5:0]},
                                           status: esd_pkg::ST_DATA};
                     end
                  end
               end
            end

            default: begin
               // Normal text.
               if (c == esd_pkg::CH_NUL) begin
                  // Held bytes go out as text, then the end.
                  for (int k = 0; k < esd_pkg::MAX_RESULTS; k++) begin
                     if (k < int'(cnt)) begin
                        bundle.slot[k] = '{data: win_q[k], status: esd_pkg::ST_DATA};
                     end
                  end
                  bundle.slot[cnt] = '{data: esd_pkg::CH_NUL, status: esd_pkg::ST_END};
                  bundle.count = cnt + 2'd1;
                  finished_in = 1'b1;
                  held_cnt_in = '0;
                  mode_in = esd_pkg::MODE_NORMAL;
               end else begin
                  // Bytes ahead of the matching offset are released as text.
                  for (int k = 0; k < esd_pkg::MAX_RESULTS; k++) begin
                     if (k < int'(sel)) begin
                        bundle.slot[k] = '{data: win_q[k], status: esd_pkg::ST_DATA};
                     end
                  end
                  if (match[sel] && span >= 3'(qlen)) begin
                     // Whole quote seen.
                     bundle.slot[sel] = '{data: esd_pkg::CH_NUL,
                                          status: esd_pkg::ST_END};
                     bundle.count = sel + 2'd1;
                     finished_in = 1'b1;
                     held_cnt_in = '0;
                     mode_in = esd_pkg::MODE_NORMAL;
                  end else if (match[sel]) begin
                     // Proper prefix of the quote: hold it.
                     bundle.count = sel;
                     held_cnt_in = 2'(span);
                     for (int j = 0; j < esd_pkg::HELD_DEPTH; j++) begin
                        if (int'(sel) + j < esd_pkg::QUOTE_MAX) begin
                           held_in[j] = win_q[int'(sel) + j];
                        end
                     end
                  end else begin
                     // The new byte stands alone.
                     held_cnt_in = '0;
                     if (c == esd_pkg::CH_BACKSLASH) begin
                        mode_in = esd_pkg::MODE_ESC;
                        bundle.count = sel;
                     end else begin
                        bundle.slot[sel] = '{data: c, status: esd_pkg::ST_DATA};
                        bundle.count = sel + 2'd1;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign push_valid = accept && (bundle.count != 2'd0);
   assign push_data = bundle;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= esd_pkg::MODE_NORMAL;
         hex_value_ff <= '0;
         hex_left_ff <= '0;
         held_cnt_ff <= '0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hex_value_ff <= hex_value_in;
         hex_left_ff <= hex_left_in;
         held_cnt_ff <= held_cnt_in;
         finished_ff <= finished_in;
      end
   end

   // Held quote bytes carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < esd_pkg::HELD_DEPTH; j++) begin
            held_ff[j] <= held_in[j];
         end
      end
   end

`ifndef SYNTHESIS
   // A finished literal keeps no held bytes and no open escape.
   assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (held_cnt_ff == 2'd0 && mode_ff == esd_pkg::MODE_NORMAL))
      else $error("finished literal with held bytes or open escape");

   // Never more held bytes than the holding store.
   assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= 2'(esd_pkg::HELD_DEPTH))
      else $error("held byte count beyond store");
`endif

endmodule

`default_nettype wire

[design/esd_queue.sv]
// Short queue of result bundles between the front and back ends of the
// string escape decoder. Depends on esd_pkg.
`default_nettype none

module esd_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   input  esd_pkg::bundle_type   push_data,
   output logic                  full,
   input  wire                   pop,
   output logic                  pop_valid,
   output esd_pkg::bundle_type   pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   esd_pkg::bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_pop = pop && pop_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = CNT_W'(count_ff + CNT_W'(push_valid) - CNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into full result queue");

   // Fill count stays within the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue count beyond depth");
`endif

endmodule

`default_nettype wire

[design/esd_back.sv]
// Back end of the string escape decoder: takes one bundle at a time from
// the queue and hands its results out one per cycle while the receiver is
// ready, marking the last. Depends on esd_pkg and esd_rsp_if.
`default_nettype none

module esd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   queue_valid,
   input  esd_pkg::bundle_type   queue_data,
   output logic                  pop,
   esd_rsp_if.source             rsp
);

   esd_pkg::bundle_type cur_ff;
   logic [1:0]          idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                is_last;
   logic                sent;
   logic                done;
   esd_pkg::slot_type   slot;

   assign slot = cur_ff.slot[idx_ff];
   assign is_last = (idx_ff == cur_ff.count - 2'd1);
   assign sent = rsp.valid && rsp.ready;
   assign done = sent && is_last;
   assign pop = (!busy_ff || done) && queue_valid;

   assign rsp.valid = busy_ff;
   assign rsp.out_byte = slot.data;
   assign rsp.status = slot.status;
   assign rsp.last = is_last;

   // Step through the slots of the current bundle.
   always_comb begin
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (sent) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= queue_data;
      end
   end

`ifndef SYNTHESIS
   // Only bundles with results reach the back end.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cur_ff.count != 2'd0)
      else $error("empty bundle in output stage");

   // The slot index stays inside the current bundle.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < cur_ff.count)
      else $error("slot index past bundle end");
`endif

endmodule

`default_nettype wire

[bench/esd_checker.sv]
// Checker for the string escape decoder: watches the request, response and
// register write channels, predicts every response and compares it.
// Depends on esd_pkg and the channel interfaces of esd_if.sv.
module esd_checker (
   input  logic   clock,
   input  logic   reset,
   esd_req_if     req_bus,
   esd_rsp_if     rsp_bus,
   esd_csr_if     csr_bus,
   output int     mismatches,
   output int     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import esd_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
   } result_type;

   // Decoded results still waiting to appear on the response channel.
   result_type decoded_q[$];

   // Register copies, as seen on the write channel.
   logic [1:0]  cfg_len;
   logic [23:0] cfg_chars;

   // Decoder state of the literal in progress.
   mode_type    mode;
   logic [15:0] hex_acc;
   logic [2:0]  digits_left;
   logic [7:0]  held [HELD_DEPTH];
   logic [1:0]  held_n;
   logic        done;
   int          step_n;

   function automatic void restart_literal();
      mode = MODE_NORMAL;
      hex_acc = '0;
      digits_left = '0;
      held_n = '0;
      done = 1'b0;
   endfunction

   function automatic void push_result(input logic [7:0] b, input logic [1:0] st);
      decoded_q.push_back('{out_byte: b, status: st, last: 1'b0});
      step_n++;
   endfunction

   // A final status closes the literal; later bytes are ignored until the next first.
   function automatic void end_literal(input logic [7:0] b, input logic [1:0] st);
      push_result(b, st);
      done = 1'b1;
      held_n = '0;
      mode = MODE_NORMAL;
   endfunction

   // Normal text: match held bytes plus the new one against the closing quote,
   // releasing the oldest byte each time the prefix match breaks.
   function automatic void text_char(input logic [7:0] c);
      logic [7:0] window[$];
      int qlen;
      int k;
      bit match;
      qlen = cfg_len;
      if (c == CH_NUL) begin
         for (int i = 0; i < held_n; i++) push_result(held[i], ST_DATA);
         end_literal(8'h00, ST_END);
         return;
      end
      for (int i = 0; i < held_n; i++) window.push_back(held[i]);
      window.push_back(c);
      while (window.size() > 0) begin
         k = (window.size() < qlen) ? window.size() : qlen;
         match = 1'b1;
         for (int i = 0; i < k; i++)
            if (window[i] != cfg_chars[8*i +: 8]) match = 1'b0;
         if (match && window.size() >= qlen) begin
            end_literal(8'h00, ST_END);
            return;
         end
         if (match) begin
            foreach (window[i]) held[i] = window[i];
            held_n = 2'(window.size());
            return;
         end
         if (window.size() == 1) begin
            held_n = '0;
            if (window[0] == CH_BACKSLASH) mode = MODE_ESC;
            else push_result(window[0], ST_DATA);
            return;
         end
         push_result(window.pop_front(), ST_DATA);
      end
   endfunction

   // The byte after a backslash.
   function automatic void escape_char(input logic [7:0] c);
      mode = MODE_NORMAL;
      case (c)
         CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH: push_result(c, ST_DATA);
         CH_B: push_result(CC_BACKSPACE, ST_DATA);
         CH_F: push_result(CC_FORMFEED, ST_DATA);
         CH_N: push_result(CC_NEWLINE, ST_DATA);
         CH_R: push_result(CC_RETURN, ST_DATA);
         CH_T: push_result(CC_TAB, ST_DATA);
         CH_ZERO: push_result(CH_NUL, ST_DATA);
         CH_X: begin
            mode = MODE_HEX_X;
            hex_acc = '0;
            digits_left = 3'd2;
         end
         CH_U: begin
            mode = MODE_HEX_U;
            hex_acc = '0;
            digits_left = 3'd4;
         end
         default: end_literal(c, ST_BAD_ESC);
      endcase
   endfunction

   // One digit of a \x or \u escape; the last digit releases the code.
   function automatic void hex_digit_char(input logic [7:0] c);
      logic [7:0] folded;
      logic [3:0] d;
      folded = c | 8'h20;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 4'(c - CH_ZERO);
      end else if (folded >= CH_LOWER_A && folded <= CH_F) begin
         d = 4'(folded - CH_LOWER_A) + 4'd10;
      end else begin
         end_literal(c, ST_BAD_HEX);
         return;
      end
      hex_acc = {hex_acc[11:0], d};
      if (digits_left != 0) digits_left--;
      if (digits_left != 0) return;
      if (mode == MODE_HEX_X || hex_acc < 16'h0080) begin
         push_result(hex_acc[7:0], ST_DATA);
      end else if (hex_acc < 16'h0800) begin
         push_result({3'b110, hex_acc[10:6]}, ST_DATA);
         push_result({2'b10, hex_acc[5:0]}, ST_DATA);
      end else begin
         push_result({4'b1110, hex_acc[15:12]}, ST_DATA);
         push_result({2'b10, hex_acc[11:6]}, ST_DATA);
         push_result({2'b10, hex_acc[5:0]}, ST_DATA);
      end
      mode = MODE_NORMAL;
      hex_acc = '0;
   endfunction

   // Predicts the results of one accepted request.
   function automatic void unescape(input logic [7:0] c, input logic starts);
      step_n = 0;
      if (starts) restart_literal();
      if (done) return;
      case (mode)
         MODE_ESC: escape_char(c);
         MODE_HEX_X, MODE_HEX_U: hex_digit_char(c);
         default: text_char(c);
      endcase
      if (step_n > 0) decoded_q[decoded_q.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   // Register writes first, then the request, then the response of this edge.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cfg_len = 2'd1;
         cfg_chars = {16'h0000, CH_DQUOTE};
         restart_literal();
         decoded_q.delete();
         mismatches = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_QUOTE_LEN) cfg_len = csr_bus.data[1:0];
            else cfg_chars = csr_bus.data;
         end
         if (req_bus.valid && req_bus.ready) unescape(req_bus.in_byte, req_bus.first);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got %0h/%0d/%0b",
                        $time, rsp_bus.out_byte, rsp_bus.status, rsp_bus.last);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.out_byte, rsp_bus.out_byte);
               check_field("status", {6'd0, want.status}, {6'd0, rsp_bus.status});
               check_field("last", {7'd0, want.last}, {7'd0, rsp_bus.last});
            end
         end
      end
      outstanding = decoded_q.size();
   end

endmodule

[bench/string_escape_decoder_unit_tb.sv]
// Top of the string escape decoder bench: clock, reset, register settings,
// request stimulus and response back-pressure, and the final verdict.
// Depends on esd_pkg, esd_if.sv, the decoder RTL and esd_checker.
module string_escape_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import esd_pkg::*;

   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 32;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT = 200000;

   // Opening requests as {first, byte}: plain extremes, escapes, \x and \u with
   // all-ones digits in both cases, the end quote, a byte after the end, a NUL
   // after a backslash, a bad hex digit, a bare NUL and an unknown escape.
   localparam logic [8:0] OPENING [27] = '{
      {1'b1, 8'hFF}, {1'b0, 8'h01}, {1'b0, CH_BACKSLASH}, {1'b0, CH_N},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_ZERO},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_X}, {1'b0, CH_UPPER_F}, {1'b0, CH_F},
      {1'b0, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, CH_UPPER_F}, {1'b0, CH_UPPER_F},
      {1'b0, CH_F}, {1'b0, CH_F}, {1'b0, CH_DQUOTE}, {1'b0, 8'h7A},
      {1'b1, CH_BACKSLASH}, {1'b0, CH_NUL},
      {1'b1, CH_BACKSLASH}, {1'b0, CH_U}, {1'b0, 8'h31}, {1'b0, 8'h67},
      {1'b1, CH_NUL},
      {1'b1, CH_BACKSLASH}, {1'b0, 8'h71}
   };

   localparam logic [7:0] ESCAPE_LETTERS [10] = '{
      CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH, CH_B,
      CH_F, CH_N, CH_R, CH_T, CH_ZERO
   };

   logic        clock = 1'b0;
   logic        reset;
   int          cycles = 0;
   int          sent;
   int          hold_left = 0;
   bit          idling = 1'b1;
   bit          squeeze = 1'b0;
   logic [1:0]  stim_len;
   logic [23:0] stim_chars;
   logic [7:0]  literal_bytes[$];
   int          mismatches;
   int          outstanding;

   esd_req_if req_bus ();
   esd_rsp_if rsp_bus ();
   esd_csr_if csr_bus ();

   string_escape_decoder_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   esd_checker watcher (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL string_escape_decoder_unit");
         $finish;
      end
   end

   // Response back-pressure: random stall bursts, plus one long hold on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (squeeze) begin
         rsp_bus.ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         squeeze = 1'b0;
      end else if (idling && $urandom_range(0, 6) == 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left = $urandom_range(0, 13);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(0, 4) == 0) begin
         c = 8'($urandom_range(1, 255));
      end else begin
         c = 8'($urandom_range(8'h20, 8'h7E));
         if (c == CH_BACKSLASH) c = CH_SLASH;
      end
      return c;
   endfunction

   // Hex digit character, letters in either case.
   function automatic logic [7:0] hex_glyph(input logic [3:0] v);
      if (v < 4'd10) return CH_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
   endfunction

   function automatic void push_quote(input int n);
      for (int i = 0; i < n; i++) literal_bytes.push_back(stim_chars[8*i +: 8]);
   endfunction

   // Offers one request from a falling edge and returns at the falling edge
   // after it was taken.
   task automatic send_byte(input logic [7:0] b, input logic starts);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.first <= starts;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic index, input logic [23:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int parts;
      int kind;
      int closing;
      logic [15:0] code;
      bit fresh;

      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.first = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_QUOTE_LEN;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening requests under the reset quote.
      stim_len = 2'd1;
      stim_chars = {16'h0000, CH_DQUOTE};
      sent = 0;
      foreach (OPENING[i]) send_byte(OPENING[i][7:0], OPENING[i][8]);

      for (int phase = 1; phase < PHASES; phase++) begin
         // Quote registers change only once the decoder has drained.
         req_bus.valid <= 1'b0;
         while (outstanding != 0) @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (phase)
            1: begin
               stim_len = 2'd3;
               stim_chars = 24'h222222;
            end
            2: begin
               stim_len = 2'd2;
               stim_chars = {8'h00, CH_DQUOTE, CH_BACKSLASH};
            end
            3: begin
               stim_len = 2'd0;
               stim_chars = 24'h000000;
            end
            4: begin
               stim_len = 2'd3;
               stim_chars = 24'hFFFFFF;
            end
            5: begin
               stim_len = 2'd3;
               stim_chars = {CH_NUL, CH_SQUOTE, CH_DQUOTE};
            end
            default: begin
               stim_len = 2'($urandom_range(1, 3));
               stim_chars = 24'($urandom_range(0, 24'hFFFFFF));
            end
         endcase
         write_reg(CSR_QUOTE_LEN, {22'd0, stim_len});
         write_reg(CSR_QUOTE_CHARS, stim_chars);
         csr_bus.valid <= 1'b0;
         if (phase == 1) squeeze = 1'b1;
         idling = (phase != PHASES - 1);

         // Half the time the first literal carries on from the previous phase.
         fresh = 1'($urandom_range(0, 1));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            literal_bytes.delete();
            parts = $urandom_range(0, 6);
            repeat (parts) begin
               kind = $urandom_range(0, 15);
               if (kind <= 4) begin
                  literal_bytes.push_back(plain_char());
               end else if (kind == 5) begin
                  // Quote prefix that then breaks off.
                  if (stim_len >= 2) push_quote($urandom_range(1, stim_len - 1));
                  literal_bytes.push_back(plain_char());
               end else if (kind <= 8) begin
                  literal_bytes.push_back(CH_BACKSLASH);
                  literal_bytes.push_back(ESCAPE_LETTERS[$urandom_range(0, 9)]);
               end else if (kind <= 10) begin
                  code = 16'($urandom_range(0, 255));
                  literal_bytes.push_back(CH_BACKSLASH);
                  literal_bytes.push_back(CH_X);
                  literal_bytes.push_back(hex_glyph(code[7:4]));
                  literal_bytes.push_back(hex_glyph(code[3:0]));
               end else if (kind <= 13) begin
                  // Code points for one, two and three UTF-8 bytes.
                  case ($urandom_range(0, 2))
                     0: code = 16'($urandom_range(0, 16'h007F));
                     1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                     default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                  endcase
                  literal_bytes.push_back(CH_BACKSLASH);
                  literal_bytes.push_back(CH_U);
                  for (int d = 3; d >= 0; d--) literal_bytes.push_back(hex_glyph(code[4*d +: 4]));
               end else if (kind == 14) begin
                  literal_bytes.push_back(CH_BACKSLASH);
                  literal_bytes.push_back(8'($urandom_range(0, 255)));
               end else begin
                  // Hex escape cut short by an arbitrary byte.
                  code = 16'($urandom);
                  literal_bytes.push_back(CH_BACKSLASH);
                  literal_bytes.push_back(code[0] ? CH_X : CH_U);
                  repeat ($urandom_range(0, 3)) literal_bytes.push_back(hex_glyph(4'($urandom)));
                  literal_bytes.push_back(8'($urandom_range(0, 255)));
               end
            end
            closing = $urandom_range(0, 9);
            if (closing <= 5) begin
               push_quote(stim_len);
            end else if (closing == 6) begin
               literal_bytes.push_back(CH_NUL);
            end else if (closing == 7) begin
               if (stim_len >= 2) push_quote($urandom_range(1, stim_len - 1));
               literal_bytes.push_back(CH_NUL);
            end
            if ($urandom_range(0, 3) == 0) literal_bytes.push_back(8'($urandom_range(0, 255)));
            if (literal_bytes.size() == 0) literal_bytes.push_back(plain_char());
            foreach (literal_bytes[i]) send_byte(literal_bytes[i], fresh && i == 0);
            fresh = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS string_escape_decoder_unit");
      else
         $display("FAIL string_escape_decoder_unit");
      $finish;
   end

endmodule
